>>> sv/nnds_pkg.sv
// Shared types and constants of the nearest neighbor downscaler.
// Used by every module of the block; depends on nothing.
package nnds_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = 13;
    localparam int COORD_W       = 12;
    localparam int CHAN_COUNT_W  = 3;
    localparam int SCALE_W       = 5;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 3;
    localparam int DIV_STEPS     = DIM_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SRC_WIDTH     = 3'd0,
        REG_SRC_HEIGHT    = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_SCALE_FACTOR  = 3'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        OP_NEW_W  = 2'd0,
        OP_NEW_H  = 2'd1,
        OP_STEP_W = 2'd2,
        OP_STEP_H = 2'd3
    } t_div_op;

    typedef struct packed {
        logic    div_start;
        logic    div_capture;
        t_div_op op;
        logic    run;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_done;
        logic cfg_hit;
    } t_dp_status;

    typedef struct packed {
        logic [7:0] chan0_in;
        logic [7:0] chan1_in;
        logic [7:0] chan2_in;
        logic [7:0] chan3_in;
    } t_in_pixel;

    typedef struct packed {
        logic [7:0] chan0_out;
        logic [7:0] chan1_out;
        logic [7:0] chan2_out;
        logic [7:0] chan3_out;
        logic       end_of_row;
        logic       end_of_frame;
    } t_out_pixel;

endpackage

>>> sv/nnds_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nnds_pkg for widths and the step count.
module nnds_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [nnds_pkg::DIM_W-1:0] i_dividend,
    input  logic [nnds_pkg::DIM_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [nnds_pkg::DIM_W-1:0] o_quotient,
    output logic [nnds_pkg::DIM_W-1:0] o_remainder
);

    logic                           r_busy;
    logic                           r_done;
    logic [nnds_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [nnds_pkg::DIM_W-1:0]     r_quo;
    logic [nnds_pkg::DIM_W-1:0]     r_rem;
    logic [nnds_pkg::DIM_W-1:0]     r_div;
    logic [nnds_pkg::DIM_W:0]       w_shift;
    logic [nnds_pkg::DIM_W:0]       w_diff;
    logic                           w_ge;
    logic [nnds_pkg::DIM_W-1:0]     n_rem;
    logic [nnds_pkg::DIM_W-1:0]     n_quo;

    always_comb begin
        w_shift = {r_rem, r_quo[nnds_pkg::DIM_W-1]};
        w_ge    = w_shift >= {1'b0, r_div};
        w_diff  = w_shift - {1'b0, r_div};
        n_rem   = w_ge ? w_diff[nnds_pkg::DIM_W-1:0] : w_shift[nnds_pkg::DIM_W-1:0];
        n_quo   = {r_quo[nnds_pkg::DIM_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= nnds_pkg::DIV_CNT_W'(nnds_pkg::DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == nnds_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> sv/nnds_dp.sv
// Datapath: configuration registers, position counters, pick stepping and output register.
// Depends on nnds_pkg and instantiates nnds_div.
module nnds_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  nnds_pkg::t_ctrl_cmd                 i_cmd,
    output nnds_pkg::t_dp_status                o_status,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  nnds_pkg::t_in_pixel                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output nnds_pkg::t_out_pixel                o_out_data,
    input  logic                                i_cfg_we,
    input  logic [nnds_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [nnds_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int DW = nnds_pkg::DIM_W;
    localparam int CW = nnds_pkg::COORD_W;

    logic [DW-1:0]                     r_src_width;
    logic [DW-1:0]                     r_src_height;
    logic [nnds_pkg::CHAN_COUNT_W-1:0] r_channel_count;
    logic [nnds_pkg::SCALE_W-1:0]      r_scale_factor;

    logic [DW-1:0] r_scaled_w;
    logic [DW-1:0] r_scaled_h;
    logic [DW-1:0] r_step_w_q;
    logic [DW-1:0] r_step_w_r;
    logic [DW-1:0] r_step_h_q;
    logic [DW-1:0] r_step_h_r;

    logic [CW-1:0] r_src_col, n_src_col;
    logic [CW-1:0] r_src_row, n_src_row;
    logic [DW-1:0] r_out_col, n_out_col;
    logic [DW-1:0] r_out_row, n_out_row;
    logic [DW-1:0] r_pick_col, n_pick_col;
    logic [DW-1:0] r_col_rem, n_col_rem;
    logic [DW-1:0] r_pick_row, n_pick_row;
    logic [DW-1:0] r_row_rem, n_row_rem;

    logic                 r_out_valid;
    nnds_pkg::t_out_pixel r_out_data;
    nnds_pkg::t_out_pixel w_result;

    logic [DW-1:0] w_eff_w;
    logic [DW-1:0] w_eff_h;
    logic [DW-1:0] w_eff_s;
    logic          w_cfg_hit;
    logic          w_accept;
    logic          w_row_hit;
    logic          w_emit;
    logic          w_col_last;
    logic          w_row_last;
    logic [DW:0]   w_col_sum;
    logic          w_col_wrap;
    logic [DW:0]   w_row_sum;
    logic          w_row_wrap;

    logic [DW-1:0] w_div_dividend;
    logic [DW-1:0] w_div_divisor;
    logic          w_div_done;
    logic [DW-1:0] w_div_quo;
    logic [DW-1:0] w_div_rem;

    always_comb begin
        if (r_src_width == '0) begin
            w_eff_w = DW'(1);
        end else if (r_src_width > DW'(nnds_pkg::MAX_DIMENSION)) begin
            w_eff_w = DW'(nnds_pkg::MAX_DIMENSION);
        end else begin
            w_eff_w = r_src_width;
        end
        if (r_src_height == '0) begin
            w_eff_h = DW'(1);
        end else if (r_src_height > DW'(nnds_pkg::MAX_DIMENSION)) begin
            w_eff_h = DW'(nnds_pkg::MAX_DIMENSION);
        end else begin
            w_eff_h = r_src_height;
        end
        if (r_scale_factor == '0) begin
            w_eff_s = DW'(1);
        end else begin
            w_eff_s = DW'(r_scale_factor);
        end
    end

    always_comb begin
        case (i_cmd.op)
            nnds_pkg::OP_NEW_W: begin
                w_div_dividend = w_eff_w;
                w_div_divisor  = w_eff_s;
            end
            nnds_pkg::OP_NEW_H: begin
                w_div_dividend = w_eff_h;
                w_div_divisor  = w_eff_s;
            end
            nnds_pkg::OP_STEP_W: begin
                w_div_dividend = w_eff_w;
                w_div_divisor  = r_scaled_w;
            end
            nnds_pkg::OP_STEP_H: begin
                w_div_dividend = w_eff_h;
                w_div_divisor  = r_scaled_h;
            end
            default: begin
                w_div_dividend = w_eff_w;
                w_div_divisor  = w_eff_s;
            end
        endcase
    end

    nnds_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (w_div_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    always_comb begin
        case (i_cfg_index)
            nnds_pkg::REG_SRC_WIDTH,
            nnds_pkg::REG_SRC_HEIGHT,
            nnds_pkg::REG_CHANNEL_COUNT,
            nnds_pkg::REG_SCALE_FACTOR: w_cfg_hit = i_cfg_we;
            default:                    w_cfg_hit = 1'b0;
        endcase
    end

    assign o_status.div_done = w_div_done;
    assign o_status.cfg_hit  = w_cfg_hit;

    assign o_in_stall = !i_cmd.run || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_row_hit  = (r_out_row < r_scaled_h) && ({1'b0, r_src_row} == r_pick_row);
        w_emit     = w_row_hit && (r_out_col < r_scaled_w) && ({1'b0, r_src_col} == r_pick_col);
        w_col_last = ({1'b0, r_src_col} + DW'(1)) >= w_eff_w;
        w_row_last = ({1'b0, r_src_row} + DW'(1)) >= w_eff_h;
        w_col_sum  = {1'b0, r_col_rem} + {1'b0, r_step_w_r};
        w_col_wrap = w_col_sum >= {1'b0, r_scaled_w};
        w_row_sum  = {1'b0, r_row_rem} + {1'b0, r_step_h_r};
        w_row_wrap = w_row_sum >= {1'b0, r_scaled_h};

        w_result.chan0_out    = (r_channel_count > 3'd0) ? i_in_data.chan0_in : 8'd0;
        w_result.chan1_out    = (r_channel_count > 3'd1) ? i_in_data.chan1_in : 8'd0;
        w_result.chan2_out    = (r_channel_count > 3'd2) ? i_in_data.chan2_in : 8'd0;
        w_result.chan3_out    = (r_channel_count > 3'd3) ? i_in_data.chan3_in : 8'd0;
        w_result.end_of_row   = ({1'b0, r_out_col} + (DW + 1)'(1)) == {1'b0, r_scaled_w};
        w_result.end_of_frame = w_result.end_of_row
                                && (({1'b0, r_out_row} + (DW + 1)'(1)) == {1'b0, r_scaled_h});
    end

    always_comb begin
        n_src_col  = r_src_col;
        n_src_row  = r_src_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_pick_col = r_pick_col;
        n_col_rem  = r_col_rem;
        n_pick_row = r_pick_row;
        n_row_rem  = r_row_rem;
        if (w_emit) begin
            n_out_col  = r_out_col + DW'(1);
            n_pick_col = r_pick_col + r_step_w_q + DW'(w_col_wrap);
            n_col_rem  = w_col_wrap ? DW'(w_col_sum - {1'b0, r_scaled_w}) : w_col_sum[DW-1:0];
        end
        if (w_col_last) begin
            n_src_col  = '0;
            n_out_col  = '0;
            n_pick_col = '0;
            n_col_rem  = '0;
            if (w_row_hit) begin
                n_out_row  = r_out_row + DW'(1);
                n_pick_row = r_pick_row + r_step_h_q + DW'(w_row_wrap);
                n_row_rem  = w_row_wrap ? DW'(w_row_sum - {1'b0, r_scaled_h})
                                        : w_row_sum[DW-1:0];
            end
            if (w_row_last) begin
                n_src_row  = '0;
                n_out_row  = '0;
                n_pick_row = '0;
                n_row_rem  = '0;
            end else begin
                n_src_row = r_src_row + CW'(1);
            end
        end else begin
            n_src_col = r_src_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width     <= DW'(1);
            r_src_height    <= DW'(1);
            r_channel_count <= nnds_pkg::CHAN_COUNT_W'(4);
            r_scale_factor  <= nnds_pkg::SCALE_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nnds_pkg::REG_SRC_WIDTH:     r_src_width     <= i_cfg_data[DW-1:0];
                nnds_pkg::REG_SRC_HEIGHT:    r_src_height    <= i_cfg_data[DW-1:0];
                nnds_pkg::REG_CHANNEL_COUNT:
                    r_channel_count <= i_cfg_data[nnds_pkg::CHAN_COUNT_W-1:0];
                nnds_pkg::REG_SCALE_FACTOR:
                    r_scale_factor  <= i_cfg_data[nnds_pkg::SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scaled_w <= '0;
            r_scaled_h <= '0;
            r_step_w_q <= '0;
            r_step_w_r <= '0;
            r_step_h_q <= '0;
            r_step_h_r <= '0;
        end else if (i_cmd.div_capture) begin
            case (i_cmd.op)
                nnds_pkg::OP_NEW_W: r_scaled_w <= w_div_quo;
                nnds_pkg::OP_NEW_H: r_scaled_h <= w_div_quo;
                nnds_pkg::OP_STEP_W: begin
                    r_step_w_q <= w_div_quo;
                    r_step_w_r <= w_div_rem;
                end
                nnds_pkg::OP_STEP_H: begin
                    r_step_h_q <= w_div_quo;
                    r_step_h_r <= w_div_rem;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_hit) begin
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_pick_col <= '0;
            r_col_rem  <= '0;
            r_pick_row <= '0;
            r_row_rem  <= '0;
        end else if (w_accept) begin
            r_src_col  <= n_src_col;
            r_src_row  <= n_src_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_pick_col <= n_pick_col;
            r_col_rem  <= n_col_rem;
            r_pick_row <= n_pick_row;
            r_row_rem  <= n_row_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> sv/nnds_ctrl.sv
// Controller: sequences the four setup divisions, then lets the pixel stream run.
// Depends on nnds_pkg for the command and status types.
module nnds_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nnds_pkg::t_dp_status i_status,
    output nnds_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_ISSUE = 3'b001,
        ST_WAIT  = 3'b010,
        ST_RUN   = 3'b100
    } t_ctrl_state;

    t_ctrl_state       r_state, n_state;
    nnds_pkg::t_div_op r_op, n_op;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            ST_ISSUE: n_state = ST_WAIT;
            ST_WAIT: begin
                if (i_status.div_done) begin
                    case (r_op)
                        nnds_pkg::OP_NEW_W: begin
                            n_op    = nnds_pkg::OP_NEW_H;
                            n_state = ST_ISSUE;
                        end
                        nnds_pkg::OP_NEW_H: begin
                            n_op    = nnds_pkg::OP_STEP_W;
                            n_state = ST_ISSUE;
                        end
                        nnds_pkg::OP_STEP_W: begin
                            n_op    = nnds_pkg::OP_STEP_H;
                            n_state = ST_ISSUE;
                        end
                        default: n_state = ST_RUN;
                    endcase
                end
            end
            ST_RUN:  n_state = ST_RUN;
            default: n_state = ST_ISSUE;
        endcase
        if (i_status.cfg_hit) begin
            n_state = ST_ISSUE;
            n_op    = nnds_pkg::OP_NEW_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ISSUE;
            r_op    <= nnds_pkg::OP_NEW_W;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        o_cmd.div_start   = (r_state == ST_ISSUE);
        o_cmd.div_capture = (r_state == ST_WAIT) && i_status.div_done;
        o_cmd.op          = r_op;
        o_cmd.run         = (r_state == ST_RUN);
    end

endmodule

>>> sv/nearest_neighbor_downscaler.sv
// Top level of the nearest neighbor downscaler: controller plus datapath.
// Depends on nnds_pkg, nnds_ctrl and nnds_dp.
//
// Source pixels enter in raster order on the input channel (i_in_valid,
// o_in_stall, i_in_data), one beat per pixel. Each pixel is either dropped or
// passed on as one output beat (o_out_valid, i_out_stall, o_out_data), which
// marks the last pixel of an output row and of the output frame.
// Configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_data; the user must write them only while the block is idle, which
// the block does not enforce. Any write to a known register restarts the frame.
// After reset and after every write to a known register the block works out
// the scaled sizes and the column and row pick steps with a shared iterative
// divider: four divisions, each started, run for 13 steps and stored, while
// o_in_stall is high. After that one pixel is taken every cycle while the
// output is not stalled. A kept pixel appears at the output register in the
// cycle after its input beat. When the receiver stalls, the output register
// holds its beat and the input is stalled as well until that beat is taken.
module nearest_neighbor_downscaler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  nnds_pkg::t_in_pixel              i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output nnds_pkg::t_out_pixel             o_out_data,
    input  logic                             i_cfg_we,
    input  logic [nnds_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [nnds_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    nnds_pkg::t_ctrl_cmd  w_cmd;
    nnds_pkg::t_dp_status w_status;

    nnds_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    nnds_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

>>> sv/nnds_checker.sv
// Port-level checks of the nearest neighbor downscaler, bound to its top level.
// Depends on nnds_pkg and nearest_neighbor_downscaler.
module nnds_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input nnds_pkg::t_out_pixel             o_out_data,
    input logic                             i_cfg_we,
    input logic [nnds_pkg::CFG_INDEX_W-1:0] i_cfg_index
);

    logic w_known_reg;

    assign w_known_reg = (i_cfg_index == nnds_pkg::REG_SRC_WIDTH)
                         || (i_cfg_index == nnds_pkg::REG_SRC_HEIGHT)
                         || (i_cfg_index == nnds_pkg::REG_CHANNEL_COUNT)
                         || (i_cfg_index == nnds_pkg::REG_SCALE_FACTOR);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled output beat changed or vanished.");

    a_frame_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.end_of_frame |-> o_out_data.end_of_row)
        else $error("End of frame without end of row.");

    a_out_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall))
        else $error("Output beat without an accepted input beat.");

    a_cfg_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && w_known_reg |=> o_in_stall)
        else $error("Input not stalled after a register write.");

endmodule

bind nearest_neighbor_downscaler nnds_checker u_nnds_checker (.*);
